// ===== hw/rtl/bmhtk_pkg.sv =====
`default_nettype none

package bmhtk_pkg;

   localparam int DEF_HEAP_DEPTH  = 1024;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int FIELD_W  = 32;
   localparam int LIMIT_W  = 11;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 3;

   localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RESET = 11'd1024;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_POP   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_REPLACED = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_POPPED   = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [FIELD_W-1:0]  popped_value;
      logic [FIELD_W-1:0]  top_value;
      logic [COUNT_W-1:0]  held_count;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bounded_max_heap_top_k.sv =====
// channel   ports                      direction  moves
// req       req_valid / req_stall      in         kind, offered value
// rsp       rsp_valid / rsp_stall      out        status, popped, top, count
// csr       csr_wr_en / csr_wr_data    in         keep limit, no read-back
//
// Registered RAM reads. Drop, pop on empty, last-value pop and first insert go
// straight to done; an insert climbs level by level toward the root, a replace
// descends level by level, and a pop reads the last value and then descends.
// Synchronous active-high reset clears the count and the limit (to 1024).
// req_stall is high while a transaction is in work; a stalled result sits in
// the rsp register and the core may take the next transaction meanwhile.
`default_nettype none

module bounded_max_heap_top_k import bmhtk_pkg::*; #(
   parameter int HEAP_DEPTH  = DEF_HEAP_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_kind,
   input  wire logic [FIELD_W-1:0]  req_offered_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [FIELD_W-1:0]       rsp_popped_value,
   output logic [FIELD_W-1:0]       rsp_top_value,
   output logic [COUNT_W-1:0]       rsp_held_count,
   input  wire logic                csr_wr_en,
   input  wire logic [LIMIT_W-1:0]  csr_wr_data
);

   logic               core_ready;
   logic               core_done;
   logic               take;
   logic               accept;
   result_type         core_res;
   logic [LIMIT_W-1:0] keep_limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;

   assign req_stall = !core_ready;
   assign accept    = req_valid && core_ready;
   assign take      = core_done && (!rsp_valid_ff || !rsp_stall);

   bmhtk_core #(
      .HEAP_DEPTH  (HEAP_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .kind       (req_kind),
      .value      (VALUE_WIDTH'($unsigned(req_offered_value))),
      .keep_limit (keep_limit_ff),
      .ready      (core_ready),
      .res_valid  (core_done),
      .res_take   (take),
      .result     (core_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         keep_limit_ff <= KEEP_LIMIT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            keep_limit_ff <= csr_wr_data;
         end
      end
      if (take) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_popped_value = rsp_ff.popped_value;
   assign rsp_top_value    = rsp_ff.top_value;
   assign rsp_held_count   = rsp_ff.held_count;

endmodule

`default_nettype wire

// ===== hw/rtl/bmhtk_core.sv =====
`default_nettype none

module bmhtk_core import bmhtk_pkg::*; #(
   parameter int HEAP_DEPTH  = DEF_HEAP_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   kind,
   input  wire logic [VALUE_WIDTH-1:0] value,
   input  wire logic [LIMIT_W-1:0]     keep_limit,
   output logic                        ready,
   output logic                        res_valid,
   input  wire logic                   res_take,
   output result_type                  result
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int PW = AW + 2;
   localparam int LW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_UP_RD   = 10'b0000000010,
      S_UP_CMP  = 10'b0000000100,
      S_UP_FIN  = 10'b0000001000,
      S_POP_RD  = 10'b0000010000,
      S_POP_GET = 10'b0000100000,
      S_DN_RDL  = 10'b0001000000,
      S_DN_RDR  = 10'b0010000000,
      S_DN_CMP  = 10'b0100000000,
      S_DONE    = 10'b1000000000
   } state_type;

   // heap storage, no reset: only entries that hold heap values are ever used
   logic [VALUE_WIDTH-1:0] mem [HEAP_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   state_type              state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] top_ff, top_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] child_ff, child_in;
   logic                   rvld_ff, rvld_in;
   logic [AW-1:0]          pos_ff, pos_in;
   status_type             status_ff, status_in;
   logic [VALUE_WIDTH-1:0] popped_ff, popped_in;

   logic [LW-1:0]          lim_raw;
   logic [LW-1:0]          act_lim;
   logic                   full;
   logic [AW-1:0]          parent;
   logic [PW-1:0]          left_idx;
   logic [PW-1:0]          right_idx;
   logic                   pick_right;
   logic [VALUE_WIDTH-1:0] pick_val;
   logic [AW-1:0]          pick_idx;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      lim_raw = LW'(keep_limit);
      if (lim_raw == '0) begin
         act_lim = LW'(1);
      end else if (lim_raw > LW'(HEAP_DEPTH)) begin
         act_lim = LW'(HEAP_DEPTH);
      end else begin
         act_lim = lim_raw;
      end
   end

   assign full       = LW'(cnt_ff) >= act_lim;
   assign parent     = AW'((pos_ff - AW'(1)) >> 1);
   assign left_idx   = PW'({pos_ff, 1'b1});
   assign right_idx  = left_idx + PW'(1);
   assign pick_right = rvld_ff && ($signed(rd_data_ff) > $signed(child_ff));
   assign pick_val   = pick_right ? rd_data_ff : child_ff;
   assign pick_idx   = pick_right ? AW'(right_idx) : AW'(left_idx);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      top_in    = top_ff;
      val_in    = val_ff;
      child_in  = child_ff;
      rvld_in   = rvld_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      rd_addr   = parent;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = val_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               popped_in = '0;
               if (kind == KIND_OFFER) begin
                  val_in = value;
                  if (!full) begin
                     status_in = ST_INSERTED;
                     cnt_in    = cnt_ff + CW'(1);
                     pos_in    = AW'(cnt_ff);
                     if (cnt_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = value;
                        top_in   = value;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_UP_RD;
                     end
                  end else if ($signed(value) >= $signed(top_ff)) begin
                     status_in = ST_DROPPED;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_REPLACED;
                     pos_in    = '0;
                     state_in  = S_DN_RDL;
                  end
               end else if (cnt_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_POPPED;
                  popped_in = top_ff;
                  cnt_in    = cnt_ff - CW'(1);
                  state_in  = (cnt_ff == CW'(1)) ? S_DONE : S_POP_RD;
               end
            end
         end

         S_UP_RD: begin
            rd_addr  = parent;
            state_in = S_UP_CMP;
         end

         S_UP_CMP: begin
            wr_en = 1'b1;
            if ($signed(rd_data_ff) >= $signed(val_ff)) begin
               state_in = S_DONE;
            end else begin
               // parent moves down into the hole
               wr_data  = rd_data_ff;
               pos_in   = parent;
               state_in = (parent == '0) ? S_UP_FIN : S_UP_RD;
            end
         end

         S_UP_FIN: begin
            wr_en    = 1'b1;
            top_in   = (pos_ff == '0) ? val_ff : top_ff;
            state_in = S_DONE;
         end

         S_POP_RD: begin
            rd_addr  = AW'(cnt_ff);
            state_in = S_POP_GET;
         end

         S_POP_GET: begin
            val_in   = rd_data_ff;
            pos_in   = '0;
            state_in = S_DN_RDL;
         end

         S_DN_RDL: begin
            rd_addr = AW'(left_idx);
            if (left_idx >= PW'(cnt_ff)) begin
               wr_en    = 1'b1;
               top_in   = (pos_ff == '0) ? val_ff : top_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_DN_RDR;
            end
         end

         S_DN_RDR: begin
            rd_addr  = AW'(right_idx);
            child_in = rd_data_ff;
            rvld_in  = right_idx < PW'(cnt_ff);
            state_in = S_DN_CMP;
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if ($signed(pick_val) > $signed(val_ff)) begin
               wr_data  = pick_val;
               top_in   = (pos_ff == '0) ? pick_val : top_ff;
               pos_in   = pick_idx;
               state_in = S_DN_RDL;
            end else begin
               top_in   = (pos_ff == '0) ? val_ff : top_ff;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      top_ff    <= top_in;
      val_ff    <= val_in;
      child_ff  <= child_in;
      rvld_ff   <= rvld_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign ready     = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      result.status       = status_ff;
      result.popped_value = FIELD_W'(popped_ff);
      result.top_value    = (cnt_ff != '0) ? FIELD_W'(top_ff) : '0;
      result.held_count   = COUNT_W'(cnt_ff);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bmhtk_checker.sv =====
`default_nettype none

module bmhtk_checker import bmhtk_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [FIELD_W-1:0]  rsp_popped_value,
   input wire logic [FIELD_W-1:0]  rsp_top_value,
   input wire logic [COUNT_W-1:0]  rsp_held_count
);

   // a stalled transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_top_value) && $stable(rsp_held_count))
      else $error("rsp changed under stall");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |->
         (rsp_popped_value == '0) && (rsp_top_value == '0) && (rsp_held_count == '0))
      else $error("pop on empty reported nonzero fields");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_held_count == '0) |-> (rsp_top_value == '0))
      else $error("empty heap shows a top value");

   a_offer_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_INSERTED) || (rsp_status == ST_REPLACED)
         || (rsp_status == ST_DROPPED)) |-> (rsp_popped_value == '0))
      else $error("offer reported a popped value");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_INSERTED) || (rsp_status == ST_REPLACED))
         |-> (rsp_held_count != '0))
      else $error("offer left heap empty");

endmodule

bind bounded_max_heap_top_k bmhtk_checker u_bmhtk_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_popped_value (rsp_popped_value),
   .rsp_top_value    (rsp_top_value),
   .rsp_held_count   (rsp_held_count)
);

`default_nettype wire

// ===== sim/tb_bounded_max_heap_top_k.sv =====
`timescale 1ns / 1ps

module tb_bounded_max_heap_top_k import bmhtk_pkg::*;;

   localparam int unsigned DEPTH          = DEF_HEAP_DEPTH;
   localparam logic [31:0] SIGN_BIT       = 32'h8000_0000;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS    = 77;

   // Mirror of the heap contents. Values are kept with the sign bit flipped
   // so that an unsigned compare orders them as signed numbers.
   class heap_mirror;
      bit [31:0]      keys [DEPTH];
      int unsigned    fill;
      logic [10:0]    keep_limit;
      result_type     pending_results [$];
      int unsigned    mismatches;

      function new();
         fill       = 0;
         keep_limit = KEEP_LIMIT_RESET;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void sift_up(int unsigned pos);
         int unsigned up;
         bit [31:0]   t;
         while (pos > 0) begin
            up = (pos - 1) / 2;
            if (keys[up] >= keys[pos]) break;
            t         = keys[up];
            keys[up]  = keys[pos];
            keys[pos] = t;
            pos       = up;
         end
      endfunction

      function void sift_down(int unsigned pos);
         int unsigned big;
         int unsigned l;
         bit [31:0]   t;
         forever begin
            big = pos;
            l   = 2 * pos + 1;
            if (l < fill && keys[l] > keys[big]) big = l;
            if (l + 1 < fill && keys[l + 1] > keys[big]) big = l + 1;
            if (big == pos) break;
            t         = keys[big];
            keys[big] = keys[pos];
            keys[pos] = t;
            pos       = big;
         end
      endfunction

      // Called once per accepted request transaction.
      function void offer_or_pop(logic kind, logic [31:0] value);
         result_type  r;
         bit [31:0]   key;
         int unsigned lim;
         r   = '0;
         lim = (keep_limit == 0) ? 1 : ((keep_limit > DEPTH) ? DEPTH : keep_limit);
         if (kind == KIND_OFFER) begin
            key = value ^ SIGN_BIT;
            if (fill < lim) begin
               keys[fill] = key;
               fill++;
               sift_up(fill - 1);
               r.status = ST_INSERTED;
            end else if (key >= keys[0]) begin
               r.status = ST_DROPPED;
            end else begin
               keys[0] = key;
               sift_down(0);
               r.status = ST_REPLACED;
            end
         end else if (fill == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.popped_value = keys[0] ^ SIGN_BIT;
            fill--;
            keys[0] = keys[fill];
            sift_down(0);
            r.status = ST_POPPED;
         end
         r.top_value  = (fill > 0) ? (keys[0] ^ SIGN_BIT) : '0;
         r.held_count = fill[COUNT_W-1:0];
         pending_results.push_back(r);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH at %0t: %0s", $time, what);
      endfunction

      function void compare_result(logic [2:0] st, logic [31:0] popped,
                                   logic [31:0] top, logic [10:0] cnt);
         result_type want;
         if (pending_results.size() == 0) begin
            flag($sformatf("unexpected result status %0d popped %0d top %0d count %0d",
                           st, $signed(popped), $signed(top), cnt));
            return;
         end
         want = pending_results.pop_front();
         if (st !== want.status || popped !== want.popped_value ||
             top !== want.top_value || cnt !== want.held_count)
            flag($sformatf({"expected status %0d popped %0d top %0d count %0d, ",
                            "got status %0d popped %0d top %0d count %0d"},
                           want.status, $signed(want.popped_value),
                           $signed(want.top_value), want.held_count,
                           st, $signed(popped), $signed(top), cnt));
      endfunction
   endclass

   logic                clock;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic                req_kind          = KIND_OFFER;
   logic [FIELD_W-1:0]  req_offered_value = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [FIELD_W-1:0]  rsp_popped_value;
   logic [FIELD_W-1:0]  rsp_top_value;
   logic [COUNT_W-1:0]  rsp_held_count;
   logic                csr_wr_en         = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data       = '0;

   heap_mirror  mirror;
   bit          req_gap_en  = 1'b0;
   bit          rsp_hold_en = 1'b0;
   int unsigned stall_left  = 0;
   int unsigned quiet_cycles = 0;

   bounded_max_heap_top_k uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_offered_value (req_offered_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_top_value     (rsp_top_value),
      .rsp_held_count    (rsp_held_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result-side backpressure: random stall bursts of random length.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rsp_hold_en && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.compare_result(rsp_status, rsp_popped_value, rsp_top_value, rsp_held_count);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2, 3, 4: return 32'($urandom_range(0, 15)) - 32'd8;  // dense, many ties
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(logic kind, logic [31:0] value);
      if (req_gap_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_offered_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.offer_or_pop(kind, value);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
   endtask

   task automatic write_limit(logic [10:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.keep_limit = v;
   endtask

   task automatic run_phase(logic [10:0] limit_value, bit calm);
      int unsigned pop_pct;
      logic        kind;
      pop_pct = 45;
      write_limit(limit_value);
      req_gap_en   = !calm && $urandom_range(0, 3) != 0;
      rsp_hold_en <= !calm && $urandom_range(0, 3) != 0;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
         // swing between filling and draining so both full and empty are hit
         if (i % 20 == 0) begin
            case ($urandom_range(0, 2))
               0:       pop_pct = 15;
               1:       pop_pct = 45;
               default: pop_pct = 80;
            endcase
         end
         if (i == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0) wait_drained();
         kind = ($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_OFFER;
         send_item(kind, pick_value());
      end
   endtask

   initial begin
      logic [10:0] limits [12];
      mirror = new();
      limits = '{11'd4, 11'd1, 11'd2047, 11'd16, 11'd64, 11'd9,
                 11'd0, 11'd2, 11'd1024, 11'd33, 11'd5, 11'd3};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, ties, drain to empty at the reset limit
      send_item(KIND_POP,   32'h1234_5678);
      send_item(KIND_OFFER, 32'h0000_0000);
      send_item(KIND_OFFER, 32'h7fff_ffff);
      send_item(KIND_OFFER, 32'h8000_0000);
      send_item(KIND_OFFER, 32'hffff_ffff);
      send_item(KIND_OFFER, 32'h7fff_ffff);
      repeat (6) send_item(KIND_POP, 32'hffff_ffff);

      // limit of one: ties and larger values dropped, smaller replaces
      write_limit(11'd1);
      send_item(KIND_OFFER, 32'd5);
      send_item(KIND_OFFER, 32'd5);
      send_item(KIND_OFFER, 32'd9);
      send_item(KIND_OFFER, -32'sd3);
      send_item(KIND_POP,   32'd0);

      // fill past a limit that is then lowered below the count
      write_limit(11'd1024);
      send_item(KIND_OFFER, 32'd10);
      send_item(KIND_OFFER, 32'd40);
      send_item(KIND_OFFER, 32'd30);
      send_item(KIND_OFFER, 32'd20);
      send_item(KIND_OFFER, 32'd50);
      write_limit(11'd2);
      send_item(KIND_OFFER, 32'd60);
      send_item(KIND_OFFER, 32'd15);
      send_item(KIND_POP,   32'd0);

      for (int p = 0; p < 12; p++)
         run_phase(limits[p], p == 11);

      wait_drained();
      repeat (40) @(posedge clock);
      if (mirror.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
